// ===== rtl/psrc_pkg.sv =====
// Shared types and codes of the port-scan reply classifier.
// Holds the request and result structs, the queued work item and the state codes.
// No dependencies.
package psrc_pkg;

	localparam int ENTRY_W     = 6;
	localparam int CODE_W      = 3;
	localparam int KIND_COUNT  = 6;
	localparam int RES_W       = CODE_W * KIND_COUNT;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_REPLY = 2'd1;
	localparam logic [1:0] CMD_SWEEP = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// reply protocols
	localparam logic [1:0] PROTO_TCP  = 2'd0;
	localparam logic [1:0] PROTO_UDP  = 2'd1;
	localparam logic [1:0] PROTO_ICMP = 2'd2;

	// scan kinds
	localparam logic [2:0] MODE_SYN = 3'd0;
	localparam logic [2:0] MODE_NUL = 3'd1;
	localparam logic [2:0] MODE_ACK = 3'd2;
	localparam logic [2:0] MODE_FIN = 3'd3;
	localparam logic [2:0] MODE_XMS = 3'd4;
	localparam logic [2:0] MODE_UDP = 3'd5;

	// port states
	localparam logic [2:0] ST_NONE   = 3'd0;
	localparam logic [2:0] ST_OPEN   = 3'd1;
	localparam logic [2:0] ST_CLOSED = 3'd2;
	localparam logic [2:0] ST_FILT   = 3'd3;
	localparam logic [2:0] ST_UNF    = 3'd4;
	localparam logic [2:0] ST_OPFI   = 3'd5;

	// ICMP destination unreachable and its codes
	localparam logic [7:0] ICMP_UNREACH = 8'd3;
	localparam logic [7:0] UNR_PORT     = 8'd3;
	localparam logic [7:0] UNR_NET_ADM  = 8'd9;
	localparam logic [7:0] UNR_HOST_ADM = 8'd10;
	localparam logic [7:0] UNR_COMM_ADM = 8'd13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd1;

	// work item opcodes
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_MATCH = 3'd1;
	localparam logic [2:0] OP_SWEEP = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_NULL  = 3'd4;

	typedef struct packed {
		logic [1:0]         command;
		logic [ENTRY_W-1:0] entry_index;
		logic [31:0]        address;
		logic [15:0]        port;
		logic [1:0]         protocol;
		logic               tcp_syn;
		logic               tcp_ack;
		logic               tcp_rst;
		logic [7:0]         msg_type;
		logic [7:0]         msg_code;
		logic [2:0]         scan_kind;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] hit_index;
		logic               matched;
		logic [CODE_W-1:0]  port_state;
	} rsp_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [ENTRY_W-1:0] idx;
		logic [31:0]        address;
		logic [15:0]        port;
		logic [2:0]         kind;
		logic               upd_en;
		logic [CODE_W-1:0]  upd_code;
	} item_t;

endpackage

// ===== rtl/psrc_front.sv =====
// Front end: takes a request and turns it into a queued work item.
// Decides the opcode and, for replies, the state code to apply.
// Depends on psrc_pkg.
module psrc_front #(
	parameter int TABLE_DEPTH = 64
) (
	input  psrc_pkg::req_t  req,
	input  logic            start,
	input  logic            full,
	input  logic [2:0]      scan_mode,
	output logic            push,
	output psrc_pkg::item_t item
);

	logic idx_ok;
	logic unreach;
	logic unreach_code;

	assign push   = start && !full;
	assign idx_ok = int'(req.entry_index) < TABLE_DEPTH;

	assign unreach      = req.msg_type == psrc_pkg::ICMP_UNREACH;
	assign unreach_code = (req.msg_code <= psrc_pkg::UNR_PORT)
		|| (req.msg_code == psrc_pkg::UNR_NET_ADM)
		|| (req.msg_code == psrc_pkg::UNR_HOST_ADM)
		|| (req.msg_code == psrc_pkg::UNR_COMM_ADM);

	always_comb begin
		item          = '0;
		item.idx      = req.entry_index;
		item.address  = req.address;
		item.port     = req.port;
		item.kind     = scan_mode;
		item.upd_en   = 1'b0;
		item.upd_code = psrc_pkg::ST_NONE;
		item.op       = psrc_pkg::OP_NULL;

		case (req.command)
			psrc_pkg::CMD_LOAD: begin
				if (idx_ok) begin
					item.op = psrc_pkg::OP_LOAD;
				end
			end
			psrc_pkg::CMD_REPLY: begin
				if (req.protocol <= psrc_pkg::PROTO_ICMP) begin
					item.op = psrc_pkg::OP_MATCH;
				end
			end
			psrc_pkg::CMD_SWEEP: begin
				if (int'(scan_mode) < psrc_pkg::KIND_COUNT) begin
					item.op = psrc_pkg::OP_SWEEP;
				end
			end
			psrc_pkg::CMD_READ: begin
				if (idx_ok) begin
					item.op = psrc_pkg::OP_READ;
				end
				item.kind = req.scan_kind;
			end
			default: begin
				item.op = psrc_pkg::OP_NULL;
			end
		endcase

		// reply classification under the current scan kind
		if (int'(scan_mode) < psrc_pkg::KIND_COUNT) begin
			case (req.protocol)
				psrc_pkg::PROTO_TCP: begin
					if (scan_mode == psrc_pkg::MODE_SYN) begin
						if (req.tcp_syn) begin
							item.upd_en   = 1'b1;
							item.upd_code = psrc_pkg::ST_OPEN;
						end else if (req.tcp_rst) begin
							item.upd_en   = 1'b1;
							item.upd_code = psrc_pkg::ST_CLOSED;
						end
					end else if (scan_mode == psrc_pkg::MODE_ACK) begin
						if (req.tcp_rst) begin
							item.upd_en   = 1'b1;
							item.upd_code = psrc_pkg::ST_UNF;
						end
					end else if (req.tcp_rst) begin
						item.upd_en   = 1'b1;
						item.upd_code = psrc_pkg::ST_CLOSED;
					end
				end
				psrc_pkg::PROTO_UDP: begin
					item.upd_en   = 1'b1;
					item.upd_code = psrc_pkg::ST_OPEN;
				end
				psrc_pkg::PROTO_ICMP: begin
					if (scan_mode == psrc_pkg::MODE_UDP && unreach
							&& req.msg_code == psrc_pkg::UNR_PORT) begin
						item.upd_en   = 1'b1;
						item.upd_code = psrc_pkg::ST_CLOSED;
					end else if (unreach && unreach_code) begin
						item.upd_en   = 1'b1;
						item.upd_code = psrc_pkg::ST_FILT;
					end
				end
				default: begin
					item.upd_en = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/psrc_queue.sv =====
// Short FIFO of work items between the front end and the table engine.
// Depends on psrc_pkg.
module psrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  psrc_pkg::item_t item_in,
	input  logic            pop,
	output logic            full,
	output logic            item_valid,
	output psrc_pkg::item_t item_out
);

	psrc_pkg::item_t             slot_q [psrc_pkg::QUEUE_DEPTH];
	logic [psrc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [psrc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [psrc_pkg::QCNT_W-1:0] count_q;

	assign full       = count_q == psrc_pkg::QCNT_W'(psrc_pkg::QUEUE_DEPTH);
	assign item_valid = count_q != '0;
	assign item_out   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/psrc_back.sv =====
// Table engine: holds the target and state memories and runs one work item at a time.
// Walks the table one entry per cycle for reply matching and the timeout sweep.
// Depends on psrc_pkg.
module psrc_back #(
	parameter int STORE_DEPTH = 64,
	parameter int IDX_W       = 6,
	parameter int CNT_W       = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  psrc_pkg::item_t item,
	input  logic [CNT_W-1:0] active_cnt,
	output logic            pop,
	output logic            done,
	output psrc_pkg::rsp_t  rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_READW = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_SWEEP = 3'd5;
	localparam logic [2:0] S_NULL  = 3'd6;

	localparam int RES_W = psrc_pkg::RES_W;

	function automatic logic [2:0] get_code(input logic [RES_W-1:0] w, input logic [2:0] k);
		logic [2:0] c;
		case (k)
			psrc_pkg::MODE_SYN: c = w[2:0];
			psrc_pkg::MODE_NUL: c = w[5:3];
			psrc_pkg::MODE_ACK: c = w[8:6];
			psrc_pkg::MODE_FIN: c = w[11:9];
			psrc_pkg::MODE_XMS: c = w[14:12];
			psrc_pkg::MODE_UDP: c = w[17:15];
			default:            c = psrc_pkg::ST_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [RES_W-1:0] set_code(input logic [RES_W-1:0] w,
			input logic [2:0] k, input logic [2:0] c);
		logic [RES_W-1:0] r;
		r = w;
		case (k)
			psrc_pkg::MODE_SYN: r[2:0]   = c;
			psrc_pkg::MODE_NUL: r[5:3]   = c;
			psrc_pkg::MODE_ACK: r[8:6]   = c;
			psrc_pkg::MODE_FIN: r[11:9]  = c;
			psrc_pkg::MODE_XMS: r[14:12] = c;
			psrc_pkg::MODE_UDP: r[17:15] = c;
			default:            r = w;
		endcase
		return r;
	endfunction

	function automatic logic [RES_W-1:0] sweep_word(input logic [RES_W-1:0] w,
			input logic [2:0] m);
		logic [2:0] c;
		logic [RES_W-1:0] r;
		c = get_code(w, m);
		r = w;
		if (m == psrc_pkg::MODE_SYN) begin
			if (c == psrc_pkg::ST_NONE) begin
				r = set_code(w, m, psrc_pkg::ST_FILT);
			end
		end else if (m == psrc_pkg::MODE_ACK) begin
			if (c == psrc_pkg::ST_NONE) begin
				c = psrc_pkg::ST_FILT;
			end
			if (get_code(w, psrc_pkg::MODE_SYN) == psrc_pkg::ST_OPEN) begin
				c = psrc_pkg::ST_UNF;
			end
			r = set_code(w, m, c);
		end else if (c == psrc_pkg::ST_NONE) begin
			r = set_code(w, m, psrc_pkg::ST_OPFI);
		end
		return r;
	endfunction

	// table memories; results are qualified by per-entry valid bits
	logic [47:0]      tgt_mem [STORE_DEPTH];
	logic [RES_W-1:0] res_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pend_s1, pend_d;
	psrc_pkg::item_t  cur_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [47:0]      tgt_rd_s1;
	logic [RES_W-1:0] res_rd_s1;

	logic [IDX_W-1:0] cur_idx;
	logic             tgt_hit;
	logic             issue;
	logic [RES_W-1:0] old_word;
	logic [2:0]       new_code;
	logic [RES_W-1:0] match_word;

	logic             res_we, tgt_we;
	logic [IDX_W-1:0] res_wa;
	logic [RES_W-1:0] res_wd;

	logic             done_d;
	psrc_pkg::rsp_t   rsp_d;
	logic             done_q;
	psrc_pkg::rsp_t   rsp_q;

	assign cur_idx    = cur_q.idx[IDX_W-1:0];
	assign pop        = (state_q == S_IDLE) && item_valid;
	assign rd_addr    = (state_q == S_READ) ? cur_idx : cnt_q[IDX_W-1:0];
	assign issue      = cnt_q < active_cnt;
	assign tgt_hit    = pend_s1 && (tgt_rd_s1 == {cur_q.address, cur_q.port});
	assign old_word   = valid_q[rd_idx_s1] ? res_rd_s1 : '0;
	assign new_code   = cur_q.upd_en ? cur_q.upd_code : get_code(old_word, cur_q.kind);
	assign match_word = set_code(old_word, cur_q.kind, new_code);

	// memory writes
	always_comb begin
		tgt_we = 1'b0;
		res_we = 1'b0;
		res_wa = rd_idx_s1;
		res_wd = match_word;
		case (state_q)
			S_LOAD: begin
				tgt_we = 1'b1;
				res_we = 1'b1;
				res_wa = cur_idx;
				res_wd = '0;
			end
			S_SCAN: begin
				res_we = tgt_hit;
			end
			S_SWEEP: begin
				res_we = pend_s1;
				res_wd = sweep_word(old_word, cur_q.kind);
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pend_d  = 1'b0;
		done_d  = 1'b0;
		rsp_d   = '0;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (item_valid) begin
					case (item.op)
						psrc_pkg::OP_LOAD:  state_d = S_LOAD;
						psrc_pkg::OP_MATCH: state_d = S_SCAN;
						psrc_pkg::OP_SWEEP: state_d = S_SWEEP;
						psrc_pkg::OP_READ:  state_d = S_READ;
						default:            state_d = S_NULL;
					endcase
				end
			end
			S_LOAD: begin
				done_d          = 1'b1;
				rsp_d.hit_index = cur_q.idx;
				rsp_d.matched   = 1'b1;
				state_d         = S_IDLE;
			end
			S_READ: begin
				state_d = S_READW;
			end
			S_READW: begin
				done_d           = 1'b1;
				rsp_d.hit_index  = cur_q.idx;
				rsp_d.matched    = 1'b1;
				rsp_d.port_state = get_code(old_word, cur_q.kind);
				state_d          = S_IDLE;
			end
			S_SCAN: begin
				if (tgt_hit) begin
					done_d           = 1'b1;
					rsp_d.hit_index  = psrc_pkg::ENTRY_W'(rd_idx_s1);
					rsp_d.matched    = 1'b1;
					rsp_d.port_state = get_code(match_word, cur_q.kind);
					state_d          = S_IDLE;
				end else if (issue) begin
					pend_d = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (issue) begin
					pend_d = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_NULL: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[cur_idx] <= {cur_q.address, cur_q.port};
		end
		if (res_we) begin
			res_mem[res_wa] <= res_wd;
		end
		tgt_rd_s1 <= tgt_mem[rd_addr];
		res_rd_s1 <= res_mem[rd_addr];
		rd_idx_s1 <= rd_addr;
		if (pop) begin
			cur_q <= item;
		end
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
			if (res_we) begin
				valid_q[res_wa] <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/port_scan_reply_classifier_core.sv =====
// Port-scan reply classifier, top level. Reply matching and the sweep walk the table
// one entry per cycle over N = min(target_count, store depth) entries; a reply stops at
// its first hit. The engine runs one request at a time, and a queue in front of it takes
// further requests until it fills. Reset clears config, queue, sequencer and all valid
// bits at once, so every state code reads as none; done cannot be stalled.
// Depends on psrc_pkg, psrc_front, psrc_queue and psrc_back.
module port_scan_reply_classifier_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  psrc_pkg::req_t                    req,
	output logic                              done,
	output psrc_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Only the first 64 entries can ever be loaded or read, so the store stops there.
	localparam int ENTRY_SPAN  = 2 ** psrc_pkg::ENTRY_W;
	localparam int STORE_DEPTH = (TABLE_DEPTH < ENTRY_SPAN) ? TABLE_DEPTH : ENTRY_SPAN;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// configuration registers
	logic [2:0]                       scan_mode_q;
	logic [psrc_pkg::CFG_DATA_W-1:0]  target_count_q;
	logic [CNT_W-1:0]                 active_cnt;

	// front to queue, queue to engine
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            pop;
	psrc_pkg::item_t front_item;
	psrc_pkg::item_t head_item;

	// Config is to be written only while idle (the block itself does not enforce that), so accept it every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q    <= psrc_pkg::MODE_SYN;
			target_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psrc_pkg::REG_SCAN_MODE:    scan_mode_q    <= cfg_data[2:0];
				psrc_pkg::REG_TARGET_COUNT: target_count_q <= cfg_data;
				default: begin
					// drop writes to unknown registers
					scan_mode_q <= scan_mode_q;
				end
			endcase
		end
	end

	// Saturate the entry count at the store depth.
	assign active_cnt = (int'(target_count_q) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH)
		: CNT_W'(target_count_q);

	// Hold off requests only when the queue is full.
	assign busy = q_full;

	psrc_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.req       (req),
		.start     (start),
		.full      (q_full),
		.scan_mode (scan_mode_q),
		.push      (push),
		.item      (front_item)
	);

	psrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (front_item),
		.pop        (pop),
		.full       (q_full),
		.item_valid (q_valid),
		.item_out   (head_item)
	);

	psrc_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (head_item),
		.active_cnt (active_cnt),
		.pop        (pop),
		.done       (done),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	// The engine returns to idle after each result, so results never come back to back.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done asserted on consecutive cycles");

	// A miss or a sweep reports all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.matched |-> rsp.hit_index == '0 && rsp.port_state == psrc_pkg::ST_NONE)
		else $error("unmatched result carries nonzero fields");

	// Only known port states are reported.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.port_state <= psrc_pkg::ST_OPFI)
		else $error("port_state out of range");

	// The queue fills only through an accepted request.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");
`endif

endmodule

// ===== test/psrc_result_checker.sv =====
// Result checker for the port-scan reply classifier: watches the request, result and
// register-write channels, predicts every result from its own copy of the target table.
// Depends on psrc_pkg.
module psrc_result_checker
	import psrc_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  req_t                  req,
	input  logic                  done,
	input  rsp_t                  rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    results_seen,
	output int                    reply_hits
);

	localparam int PRINT_CAP = 100;

	logic [31:0]      tgt_address [TABLE_DEPTH];
	logic [15:0]      tgt_port    [TABLE_DEPTH];
	logic [RES_W-1:0] tgt_states  [TABLE_DEPTH];
	logic [2:0]       mode_q;
	logic [6:0]       count_q;
	rsp_t             awaited_rsp_q [$];

	function automatic logic [CODE_W-1:0] state_of(logic [RES_W-1:0] codes, logic [2:0] kind);
		if (kind >= KIND_COUNT)
			return ST_NONE;
		return codes[kind*CODE_W +: CODE_W];
	endfunction

	function automatic logic [RES_W-1:0] with_state(logic [RES_W-1:0] codes, logic [2:0] kind,
			logic [CODE_W-1:0] code);
		logic [RES_W-1:0] upd;
		upd = codes;
		if (kind < KIND_COUNT)
			upd[kind*CODE_W +: CODE_W] = code;
		return upd;
	endfunction

	function automatic logic [RES_W-1:0] after_reply(logic [RES_W-1:0] codes, req_t r,
			logic [2:0] mode);
		logic [RES_W-1:0] upd;
		logic             unreach;
		upd     = codes;
		unreach = r.msg_type == ICMP_UNREACH &&
			(r.msg_code <= UNR_PORT || r.msg_code == UNR_NET_ADM ||
			 r.msg_code == UNR_HOST_ADM || r.msg_code == UNR_COMM_ADM);
		if (mode >= KIND_COUNT)
			return upd;
		case (r.protocol)
			PROTO_TCP: begin
				if (mode == MODE_SYN) begin
					if (r.tcp_syn)
						upd = with_state(upd, mode, ST_OPEN);
					else if (r.tcp_rst)
						upd = with_state(upd, mode, ST_CLOSED);
				end else if (mode == MODE_ACK) begin
					if (r.tcp_rst)
						upd = with_state(upd, mode, ST_UNF);
				end else if (r.tcp_rst) begin
					upd = with_state(upd, mode, ST_CLOSED);
				end
			end
			PROTO_UDP: upd = with_state(upd, mode, ST_OPEN);
			PROTO_ICMP: begin
				if (mode == MODE_UDP && r.msg_type == ICMP_UNREACH &&
						r.msg_code == UNR_PORT)
					upd = with_state(upd, mode, ST_CLOSED);
				else if (unreach)
					upd = with_state(upd, mode, ST_FILT);
			end
			default: ;
		endcase
		return upd;
	endfunction

	function automatic logic [RES_W-1:0] after_sweep(logic [RES_W-1:0] codes, logic [2:0] mode);
		logic [RES_W-1:0] upd;
		upd = codes;
		if (mode >= KIND_COUNT)
			return upd;
		if (mode == MODE_SYN || mode == MODE_ACK) begin
			if (state_of(upd, mode) == ST_NONE)
				upd = with_state(upd, mode, ST_FILT);
			// an ack scan overrides with unfiltered where the syn scan found the port open
			if (mode == MODE_ACK && state_of(upd, MODE_SYN) == ST_OPEN)
				upd = with_state(upd, mode, ST_UNF);
		end else if (state_of(upd, mode) == ST_NONE) begin
			upd = with_state(upd, mode, ST_OPFI);
		end
		return upd;
	endfunction

	task automatic classify_request(input req_t r, output rsp_t res);
		int span;
		bit found;
		res   = '0;
		found = 1'b0;
		span  = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
		case (r.command)
			CMD_LOAD: begin
				if (r.entry_index < TABLE_DEPTH) begin
					tgt_address[r.entry_index] = r.address;
					tgt_port[r.entry_index]    = r.port;
					tgt_states[r.entry_index]  = '0;
					res.hit_index              = r.entry_index;
					res.matched                = 1'b1;
				end
			end
			CMD_REPLY: begin
				if (r.protocol <= PROTO_ICMP) begin
					for (int i = 0; i < span && !found; i++) begin
						if (tgt_address[i] == r.address && tgt_port[i] == r.port) begin
							found          = 1'b1;
							tgt_states[i]  = after_reply(tgt_states[i], r, mode_q);
							res.hit_index  = ENTRY_W'(i);
							res.matched    = 1'b1;
							res.port_state = state_of(tgt_states[i], mode_q);
						end
					end
				end
				if (found)
					reply_hits++;
			end
			CMD_SWEEP: begin
				for (int i = 0; i < span; i++)
					tgt_states[i] = after_sweep(tgt_states[i], mode_q);
			end
			CMD_READ: begin
				if (r.entry_index < TABLE_DEPTH) begin
					res.hit_index  = r.entry_index;
					res.matched    = 1'b1;
					res.port_state = state_of(tgt_states[r.entry_index], r.scan_kind);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t predicted;
		rsp_t oldest;
		if (!arst_n) begin
			mode_q  = MODE_SYN;
			count_q = '0;
			foreach (tgt_states[i])
				tgt_states[i] = '0;
			awaited_rsp_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (awaited_rsp_q.size() == 0) begin
					report_mismatch("result with no request behind it", 32'(rsp), 32'(0));
				end else begin
					oldest = awaited_rsp_q.pop_front();
					if (rsp.hit_index !== oldest.hit_index)
						report_mismatch("hit_index", 32'(rsp.hit_index),
							32'(oldest.hit_index));
					if (rsp.matched !== oldest.matched)
						report_mismatch("matched", 32'(rsp.matched), 32'(oldest.matched));
					if (rsp.port_state !== oldest.port_state)
						report_mismatch("port_state", 32'(rsp.port_state),
							32'(oldest.port_state));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCAN_MODE)
					mode_q = cfg_data[2:0];
				else if (cfg_index == REG_TARGET_COUNT)
					count_q = cfg_data;
			end
			if (start && !busy) begin
				classify_request(req, predicted);
				awaited_rsp_q.push_back(predicted);
			end
			pending <= awaited_rsp_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Top of the port-scan reply classifier testbench: makes requests and register writes,
// idles at random between them and gives the verdict.
// Depends on psrc_pkg, port_scan_reply_classifier_core and psrc_result_checker.
module tb;
	import psrc_pkg::*;

	localparam int TABLE_DEPTH    = 64;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_REQUESTS = 80;
	// slowest quiet stretch: the longest random gap plus a full 64-entry walk, taken many times over
	localparam int QUIET_LIMIT    = 2000;

	// values outside the defined sets, written by name like the rest
	localparam logic [2:0]           MODE_UNDEF    = 3'd7;
	localparam logic [2:0]           KIND_UNDEF    = 3'd6;
	localparam logic [1:0]           PROTO_UNDEF   = 2'd3;
	localparam logic [7:0]           ICMP_ECHO     = 8'd8;
	localparam logic [7:0]           UNR_HOST_PREC = 8'd14;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3   = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	req_t                  req       = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_ready;

	int errors;
	int pending;
	int results_seen;
	int reply_hits;
	int requests_sent;
	int reg_writes;
	int settings_used;
	int quiet_cycles;

	// stimulus-side copy of the loaded targets, used to aim replies at live entries
	logic [31:0] table_address [TABLE_DEPTH];
	logic [15:0] table_port    [TABLE_DEPTH];
	logic [6:0]  cur_count;
	bit          no_gaps;

	port_scan_reply_classifier_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	psrc_result_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.results_seen(results_seen),
		.reply_hits  (reply_hits)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Count cycles in which no channel moves anything; give up once the limit is hit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no progress for %0d cycles, %0d results still owed", QUIET_LIMIT, pending);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Fill every field with random bits; callers then overwrite what matters.
	function automatic req_t noise_req();
		req_t r;
		r.command     = 2'($urandom);
		r.entry_index = ENTRY_W'($urandom);
		r.address     = $urandom;
		r.port        = 16'($urandom);
		r.protocol    = 2'($urandom);
		r.tcp_syn     = 1'($urandom);
		r.tcp_ack     = 1'($urandom);
		r.tcp_rst     = 1'($urandom);
		r.msg_type    = 8'($urandom);
		r.msg_code    = 8'($urandom);
		r.scan_kind   = 3'($urandom);
		return r;
	endfunction

	function automatic req_t reply_to(input int slot, input logic [1:0] proto,
			input logic syn, input logic rst, input logic [7:0] itype, input logic [7:0] icode);
		req_t r;
		r          = noise_req();
		r.command  = CMD_REPLY;
		r.address  = table_address[slot];
		r.port     = table_port[slot];
		r.protocol = proto;
		r.tcp_syn  = syn;
		r.tcp_rst  = rst;
		r.msg_type = itype;
		r.msg_code = icode;
		return r;
	endfunction

	function automatic req_t read_of(input int slot, input logic [2:0] kind);
		req_t r;
		r             = noise_req();
		r.command     = CMD_READ;
		r.entry_index = ENTRY_W'(slot);
		r.scan_kind   = kind;
		return r;
	endfunction

	function automatic req_t sweep_req();
		req_t r;
		r         = noise_req();
		r.command = CMD_SWEEP;
		return r;
	endfunction

	// Mostly replies aimed at live entries inside the searched range, with loads that
	// reshuffle the table, occasional sweeps and reads, and a tail of unmatched noise.
	function automatic req_t random_request();
		req_t r;
		int   span;
		int   slot;
		int   roll;
		r    = noise_req();
		span = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			r.command = CMD_LOAD;
			// reuse a live target now and then so an earlier entry shadows a later one
			if ($urandom_range(0, 3) == 0) begin
				slot      = $urandom_range(0, TABLE_DEPTH - 1);
				r.address = table_address[slot];
				r.port    = table_port[slot];
			end
		end else if (roll < 70) begin
			r.command = CMD_REPLY;
			roll      = $urandom_range(0, 99);
			if (roll < 80 && span > 0)
				slot = $urandom_range(0, span - 1);
			else
				slot = $urandom_range(0, TABLE_DEPTH - 1);
			if (roll < 92) begin
				r.address = table_address[slot];
				r.port    = table_port[slot];
			end
			roll = $urandom_range(0, 99);
			if (roll < 40)
				r.protocol = PROTO_TCP;
			else if (roll < 55)
				r.protocol = PROTO_UDP;
			else if (roll < 95)
				r.protocol = PROTO_ICMP;
			else
				r.protocol = PROTO_UNDEF;
			// keep most ICMP replies in the unreachable family where the codes matter
			if ($urandom_range(0, 4) != 0)
				r.msg_type = ICMP_UNREACH;
			if ($urandom_range(0, 3) != 0)
				r.msg_code = 8'($urandom_range(0, 15));
		end else if (roll < 77) begin
			r.command = CMD_SWEEP;
		end else begin
			r.command = CMD_READ;
		end
		return r;
	endfunction

	// Hold start and the request until the block takes it; keep start high across
	// back-to-back requests so it is never dropped and raised in the same step.
	task automatic issue(input req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
		if (r.command == CMD_LOAD) begin
			table_address[r.entry_index] = r.address;
			table_port[r.entry_index]    = r.port;
		end
	endtask

	// Drop start and wait for every owed result; each request yields one, so the
	// block is idle once the count reaches zero.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == REG_TARGET_COUNT)
			cur_count = val;
	endtask

	// Switch scan kind and search range between phases; now and then poke a spare index.
	task automatic set_scan(input logic [2:0] mode, input logic [6:0] count);
		drain();
		if ($urandom_range(0, 1) == 0)
			write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
				CFG_DATA_W'($urandom));
		write_reg(REG_SCAN_MODE, CFG_DATA_W'(mode));
		write_reg(REG_TARGET_COUNT, count);
		settings_used++;
	endtask

	initial begin
		req_t       r;
		logic [2:0] mode;
		logic [6:0] count;
		int         n;
		cur_count = '0;
		no_gaps   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the whole table first so no reply is ever compared against an empty entry.
		// Entry 0 and the last entry carry the field extremes; entry 5 repeats entry 2.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			r             = noise_req();
			r.command     = CMD_LOAD;
			r.entry_index = ENTRY_W'(i);
			if (i == 0) begin
				r.address = '0;
				r.port    = '0;
			end else if (i == TABLE_DEPTH - 1) begin
				r.address = '1;
				r.port    = '1;
			end else if (i == 5 || $urandom_range(0, 7) == 0) begin
				n         = (i == 5) ? 2 : $urandom_range(0, i - 1);
				r.address = table_address[n];
				r.port    = table_port[n];
			end
			issue(r);
		end

		// Directed: each reply rule, the unknown codes, the shadowed duplicate,
		// saturation of the search range and an empty range.
		set_scan(MODE_SYN, 7'(TABLE_DEPTH));
		issue(reply_to(0, PROTO_TCP, 1'b1, 1'b0, '0, '0));
		issue(reply_to(TABLE_DEPTH - 1, PROTO_TCP, 1'b0, 1'b1, '0, '0));
		issue(reply_to(10, PROTO_TCP, 1'b0, 1'b0, '0, '0));
		issue(reply_to(5, PROTO_UDP, 1'b0, 1'b0, '0, '0));
		issue(reply_to(7, PROTO_ICMP, 1'b0, 1'b0, ICMP_UNREACH, UNR_COMM_ADM));
		issue(reply_to(8, PROTO_ICMP, 1'b0, 1'b0, ICMP_UNREACH, UNR_HOST_PREC));
		issue(reply_to(9, PROTO_ICMP, 1'b0, 1'b0, ICMP_ECHO, UNR_PORT));
		issue(reply_to(1, PROTO_UNDEF, 1'b1, 1'b1, '0, '0));
		r      = reply_to(0, PROTO_UDP, 1'b0, 1'b0, '0, '0);
		r.port = ~r.port;
		issue(r);
		issue(sweep_req());
		issue(read_of(0, MODE_SYN));
		issue(read_of(TABLE_DEPTH - 1, KIND_UNDEF));

		set_scan(MODE_ACK, 7'h7f);
		issue(reply_to(3, PROTO_TCP, 1'b0, 1'b1, '0, '0));
		issue(sweep_req());
		issue(read_of(0, MODE_ACK));

		set_scan(MODE_UDP, 7'(TABLE_DEPTH));
		issue(reply_to(11, PROTO_ICMP, 1'b0, 1'b0, ICMP_UNREACH, UNR_PORT));
		issue(reply_to(12, PROTO_ICMP, 1'b0, 1'b0, ICMP_UNREACH, UNR_NET_ADM));
		issue(reply_to(13, PROTO_ICMP, 1'b0, 1'b0, ICMP_UNREACH, UNR_HOST_ADM));
		issue(sweep_req());
		issue(read_of(11, MODE_UDP));

		set_scan(MODE_UNDEF, 7'(TABLE_DEPTH));
		issue(reply_to(4, PROTO_UDP, 1'b0, 1'b0, '0, '0));
		issue(sweep_req());

		set_scan(MODE_FIN, 7'd0);
		issue(reply_to(0, PROTO_TCP, 1'b0, 1'b1, '0, '0));
		set_scan(MODE_NUL, 7'd1);
		issue(reply_to(0, PROTO_TCP, 1'b0, 1'b1, '0, '0));

		// Random phases: walk every scan kind, with full, saturated, tiny and empty ranges.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
			case (ph)
				0: count = 7'(TABLE_DEPTH);
				3: count = 7'h7f;
				6: count = 7'd1;
				9: count = 7'd0;
				default: begin
					if ($urandom_range(0, 3) == 0)
						count = 7'($urandom_range(0, 127));
					else
						count = 7'($urandom_range(24, TABLE_DEPTH));
				end
			endcase
			set_scan(mode, count);
			no_gaps = ($urandom_range(0, 3) == 0);
			n       = (count == 0) ? PHASE_REQUESTS / 4 : PHASE_REQUESTS;
			repeat (n)
				issue(random_request());
		end

		// Let the last result land, then allow a full table walk for anything stray.
		drain();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("covered %0d requests (%0d replies hit an entry), %0d register writes",
			requests_sent, reply_hits, reg_writes);
		$display("over %0d scan settings; %0d results checked, %0d mismatches, %0d owed",
			settings_used, results_seen, errors, pending);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psrc_pkg.sv
rtl/psrc_front.sv
rtl/psrc_queue.sv
rtl/psrc_back.sv
rtl/port_scan_reply_classifier_core.sv
test/psrc_result_checker.sv
test/tb.sv
